// File: hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, codes and types of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int NUM_PAGES_DEF = 1024;
	localparam int MAX_RUN       = 64;
	localparam int WORD_BITS     = 64;
	localparam int WORD_SHIFT    = 6;

	// operation codes
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_TAKE    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	// zone codes
	localparam logic [1:0] SEL_DMA    = 2'd0;
	localparam logic [1:0] SEL_NORMAL = 2'd1;
	localparam logic [1:0] SEL_HIGH   = 2'd2;
	localparam logic [1:0] SEL_BAD    = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_RUN   = 2'd1;
	localparam logic [1:0] STAT_BAD_ZONE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_DMA_TOP    = 2'd0;
	localparam logic [1:0] REG_NORMAL_TOP = 2'd1;
	localparam logic [1:0] REG_HIGH_BASE  = 2'd2;
	localparam logic [1:0] REG_HIGH_TOP   = 2'd3;

	localparam logic [9:0] DMA_TOP_RST    = 10'd15;
	localparam logic [9:0] NORMAL_TOP_RST = 10'd511;
	localparam logic [9:0] HIGH_BASE_RST  = 10'd512;
	localparam logic [9:0] HIGH_TOP_RST   = 10'd1023;

	// attribute bits that make a page shared
	localparam logic [7:0] ATTR_REF   = 8'h01;
	localparam logic [7:0] ATTR_SHARE = 8'h02;
	localparam logic [7:0] ATTR_HOLD  = ATTR_REF | ATTR_SHARE;

	typedef struct packed {
		logic       used;
		logic [7:0] attr;
		logic [7:0] refs;
	} page_ent_t;

	typedef struct packed {
		page_ent_t ent;
		logic      take_free;
		logic      give_free;
	} page_upd_t;

endpackage

// File: hdl/bpa_page_upd.sv
// ----------------------------------------------------------------------------
// bpa_page_upd
// claim and release rules for one page entry
// ----------------------------------------------------------------------------
module bpa_page_upd (
	input  logic               release_op,
	input  bpa_pkg::page_ent_t cur,
	input  logic [7:0]         flags,
	output bpa_pkg::page_upd_t upd
);

	logic       hold;
	logic [7:0] refs_up;
	logic [7:0] refs_dn;

	always_comb begin
		hold    = |((cur.attr | flags) & bpa_pkg::ATTR_HOLD);
		refs_up = (cur.refs == 8'hff) ? cur.refs : cur.refs + 8'd1;
		refs_dn = (cur.refs == 8'd0) ? cur.refs : cur.refs - 8'd1;
		upd.ent       = cur;
		upd.take_free = 1'b0;
		upd.give_free = 1'b0;
		if (!release_op) begin
			if (cur.attr == 8'd0) begin
				upd.ent.used  = 1'b1;
				upd.take_free = !cur.used;
				upd.ent.attr  = flags;
				upd.ent.refs  = refs_up;
			end else if (hold) begin
				upd.ent.attr = cur.attr | flags;
				upd.ent.refs = refs_up;
			end else begin
				upd.ent.used  = 1'b1;
				upd.take_free = !cur.used;
				upd.ent.attr  = cur.attr | flags;
			end
		end else if (cur.attr != 8'd0) begin
			if (|(cur.attr & bpa_pkg::ATTR_HOLD)) begin
				upd.ent.refs = refs_dn;
				if (refs_dn == 8'd0) begin
					upd.ent.attr  = 8'd0;
					upd.ent.used  = 1'b0;
					upd.give_free = cur.used;
				end
			end else begin
				upd.ent.used  = 1'b0;
				upd.give_free = cur.used;
				upd.ent.attr  = 8'd0;
				upd.ent.refs  = 8'd0;
			end
		end
	end

endmodule

// File: hdl/bpa_run_find.sv
// ----------------------------------------------------------------------------
// bpa_run_find
// finds the lowest free run of a given length ending in the current word
// ----------------------------------------------------------------------------
module bpa_run_find (
	input  logic [63:0] prev_free,
	input  logic [63:0] cur_free,
	input  logic [6:0]  len,
	output logic        hit,
	output logic [5:0]  pos
);

	logic [127:0] g [0:6];
	logic [127:0] r;
	logic [63:0]  hits;
	logic [7:0]   acc;

	// g[b] bit i: pages i-2^b+1 .. i all free
	always_comb begin
		g[0] = {cur_free, prev_free};
		for (int b = 1; b < 7; b++) begin
			g[b] = g[b-1] & (g[b-1] << (1 << (b - 1)));
		end
		r   = '1;
		acc = 8'd0;
		for (int b = 0; b < 7; b++) begin
			if (len[b]) begin
				r   = r & (g[b] << acc);
				acc = acc + 8'(1 << b);
			end
		end
		hits = r[127:64];
		hit  = |hits;
		pos  = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (hits[i]) begin
				pos = 6'(i);
			end
		end
	end

endmodule

// File: hdl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit page allocator over a used bitmap with per-page flags and counts
// ----------------------------------------------------------------------------
// After reset the block clears its memories page by page with busy high. An
// operation is taken when start is high and busy low; its result shows for one
// cycle with done high and cannot be held off. Take and release read the page
// entry, write it back, then show the result. Alloc reads the bitmap one 64-page
// word at a time across the zone window, then claims each page of the run with a
// read and a write-back, then shows the result; the bitmap and page memories are
// single-port. An alloc that finds no run reports once the last word of the
// window is scanned. Operations refused at the transfer and the unused code
// report in the cycle after the transfer.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
	parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [1:0]  zone_sel,
	input  logic [6:0]  run_length,
	input  logic [9:0]  page_index,
	input  logic [7:0]  flags,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [9:0]  first_page,
	output logic [7:0]  ref_count_out,
	output logic [10:0] free_pages
);

	localparam int PW = $clog2(NUM_PAGES);
	localparam int FW = $clog2(NUM_PAGES + 1);
	localparam int AW = ((PW > 11) ? PW : 11) + 1;
	localparam int NW = (NUM_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
	localparam int WA = (NW > 1) ? $clog2(NW) : 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SC_RD = 3'd2;
	localparam logic [2:0] ST_SC_EV = 3'd3;
	localparam logic [2:0] ST_CL_RD = 3'd4;
	localparam logic [2:0] ST_CL_WR = 3'd5;

	// memories: used bitmap in 64-page words, flag byte and count per page
	logic [63:0] bm_mem [0:NW-1];
	logic [15:0] pg_mem [0:NUM_PAGES-1];
	logic [63:0] bm_rdata_q;
	logic [15:0] pg_rdata_q;
	logic [WA-1:0] bm_addr;
	logic [PW-1:0] pg_addr;
	logic          bm_we;
	logic          pg_we;
	logic [63:0]   bm_wdata;
	logic [15:0]   pg_wdata;

	logic [2:0]    state_q;
	logic [PW-1:0] clr_q;
	logic [9:0]    dma_top_q;
	logic [9:0]    normal_top_q;
	logic [9:0]    high_base_q;
	logic [9:0]    high_top_q;
	logic          alloc_q;
	logic          rel_q;
	logic [6:0]    n_q;
	logic [7:0]    flags_q;
	logic [PW-1:0] lo_q;
	logic [PW-1:0] hi_q;
	logic [WA-1:0] word_q;
	logic [63:0]   prev_q;
	logic [PW-1:0] page_q;
	logic [PW-1:0] first_q;
	logic [6:0]    cnt_q;
	logic [7:0]    refs_first_q;
	logic [FW-1:0] free_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [9:0]    first_out_q;
	logic [7:0]    refs_out_q;

	// window of the requested zone
	logic [AW-1:0] win_lo;
	logic [AW-1:0] win_hi;
	logic          win_ok;
	logic          n_ok;
	logic          page_ok;

	always_comb begin
		case (zone_sel)
			bpa_pkg::SEL_DMA: begin
				win_lo = '0;
				win_hi = AW'(dma_top_q);
			end
			bpa_pkg::SEL_NORMAL: begin
				win_lo = AW'(dma_top_q) + AW'(1);
				win_hi = AW'(normal_top_q);
			end
			bpa_pkg::SEL_HIGH: begin
				win_lo = AW'(high_base_q);
				win_hi = AW'(high_top_q);
			end
			default: begin
				win_lo = AW'(1);
				win_hi = '0;
			end
		endcase
		if (win_hi > AW'(NUM_PAGES - 1)) begin
			win_hi = AW'(NUM_PAGES - 1);
		end
		win_ok  = (win_lo <= win_hi);
		n_ok    = (run_length != 7'd0) && (run_length <= 7'(bpa_pkg::MAX_RUN));
		page_ok = (AW'(page_index) < AW'(NUM_PAGES));
	end

	// scan of one bitmap word
	logic [WA-1:0] wlo;
	logic [WA-1:0] whi;
	logic [63:0]   lo_mask;
	logic [63:0]   hi_mask;
	logic [63:0]   cur_free;
	logic          fd_hit;
	logic [5:0]    fd_pos;
	logic [AW-1:0] run_first;

	assign wlo      = WA'(lo_q >> bpa_pkg::WORD_SHIFT);
	assign whi      = WA'(hi_q >> bpa_pkg::WORD_SHIFT);
	assign lo_mask  = (word_q == wlo) ? ({64{1'b1}} << lo_q[5:0]) : {64{1'b1}};
	assign hi_mask  = (word_q == whi) ? ({64{1'b1}} >> (6'd63 - hi_q[5:0])) : {64{1'b1}};
	assign cur_free = ~bm_rdata_q & lo_mask & hi_mask;
	assign run_first = (AW'(word_q) << bpa_pkg::WORD_SHIFT) + AW'(fd_pos) + AW'(1)
		- AW'(n_q);

	bpa_run_find u_find (
		.prev_free (prev_q),
		.cur_free  (cur_free),
		.len       (n_q),
		.hit       (fd_hit),
		.pos       (fd_pos)
	);

	// read-modify-write of one page entry
	bpa_pkg::page_ent_t cur_ent;
	bpa_pkg::page_upd_t upd;

	assign cur_ent.used = bm_rdata_q[page_q[5:0]];
	assign cur_ent.attr = pg_rdata_q[15:8];
	assign cur_ent.refs = pg_rdata_q[7:0];

	bpa_page_upd u_upd (
		.release_op (rel_q),
		.cur        (cur_ent),
		.flags      (flags_q),
		.upd        (upd)
	);

	always_comb begin
		bm_wdata = bm_rdata_q;
		bm_wdata[page_q[5:0]] = upd.ent.used;
		pg_wdata = {upd.ent.attr, upd.ent.refs};
		bm_we    = (state_q == ST_CL_WR);
		pg_we    = (state_q == ST_CL_WR);
		bm_addr  = WA'(page_q >> bpa_pkg::WORD_SHIFT);
		pg_addr  = page_q;
		case (state_q)
			ST_CLEAR: begin
				bm_wdata = '0;
				pg_wdata = '0;
				bm_we    = (AW'(clr_q) < AW'(NW));
				pg_we    = 1'b1;
				bm_addr  = WA'(clr_q);
				pg_addr  = clr_q;
			end
			ST_SC_RD: begin
				bm_addr = word_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_addr] <= bm_wdata;
		end
		bm_rdata_q <= bm_mem[bm_addr];
	end

	always_ff @(posedge clk) begin
		if (pg_we) begin
			pg_mem[pg_addr] <= pg_wdata;
		end
		pg_rdata_q <= pg_mem[pg_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_top_q    <= bpa_pkg::DMA_TOP_RST;
			normal_top_q <= bpa_pkg::NORMAL_TOP_RST;
			high_base_q  <= bpa_pkg::HIGH_BASE_RST;
			high_top_q   <= bpa_pkg::HIGH_TOP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bpa_pkg::REG_DMA_TOP:    dma_top_q    <= cfg_wdata;
				bpa_pkg::REG_NORMAL_TOP: normal_top_q <= cfg_wdata;
				bpa_pkg::REG_HIGH_BASE:  high_base_q  <= cfg_wdata;
				bpa_pkg::REG_HIGH_TOP:   high_top_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	logic [AW-1:0] first_ext;
	logic          last_claim;

	assign first_ext  = AW'(first_q);
	assign last_claim = !alloc_q || (cnt_q == n_q - 7'd1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			free_q  <= FW'(NUM_PAGES);
			done_q  <= 1'b0;
			status_q <= bpa_pkg::STAT_OK;
			first_out_q <= '0;
			refs_out_q  <= '0;
			alloc_q <= 1'b0;
			rel_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(NUM_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						n_q     <= run_length;
						flags_q <= flags;
						lo_q    <= PW'(win_lo);
						hi_q    <= PW'(win_hi);
						cnt_q   <= '0;
						case (op)
							bpa_pkg::OP_ALLOC: begin
								alloc_q <= 1'b1;
								rel_q   <= 1'b0;
								if (zone_sel != bpa_pkg::SEL_DMA &&
									zone_sel != bpa_pkg::SEL_NORMAL &&
									zone_sel != bpa_pkg::SEL_HIGH) begin
									done_q      <= 1'b1;
									status_q    <= bpa_pkg::STAT_BAD_ZONE;
									first_out_q <= '0;
									refs_out_q  <= '0;
								end else if (!n_ok || !win_ok) begin
									done_q      <= 1'b1;
									status_q    <= bpa_pkg::STAT_NO_RUN;
									first_out_q <= '0;
									refs_out_q  <= '0;
								end else begin
									word_q  <= WA'(PW'(win_lo) >> bpa_pkg::WORD_SHIFT);
									prev_q  <= '0;
									state_q <= ST_SC_RD;
								end
							end
							bpa_pkg::OP_TAKE, bpa_pkg::OP_RELEASE: begin
								alloc_q <= 1'b0;
								rel_q   <= (op == bpa_pkg::OP_RELEASE);
								if (!page_ok) begin
									done_q      <= 1'b1;
									status_q    <= bpa_pkg::STAT_NO_RUN;
									first_out_q <= '0;
									refs_out_q  <= '0;
								end else begin
									page_q  <= PW'(page_index);
									first_q <= PW'(page_index);
									state_q <= ST_CL_RD;
								end
							end
							default: begin
								// unused code: report only the free count
								done_q      <= 1'b1;
								status_q    <= bpa_pkg::STAT_OK;
								first_out_q <= '0;
								refs_out_q  <= '0;
							end
						endcase
					end
				end
				ST_SC_RD: begin
					state_q <= ST_SC_EV;
				end
				ST_SC_EV: begin
					if (fd_hit) begin
						page_q  <= PW'(run_first);
						first_q <= PW'(run_first);
						state_q <= ST_CL_RD;
					end else if (word_q == whi) begin
						done_q      <= 1'b1;
						status_q    <= bpa_pkg::STAT_NO_RUN;
						first_out_q <= '0;
						refs_out_q  <= '0;
						state_q     <= ST_IDLE;
					end else begin
						word_q  <= word_q + WA'(1);
						prev_q  <= cur_free;
						state_q <= ST_SC_RD;
					end
				end
				ST_CL_RD: begin
					state_q <= ST_CL_WR;
				end
				ST_CL_WR: begin
					if (upd.take_free && free_q != '0) begin
						free_q <= free_q - FW'(1);
					end else if (upd.give_free) begin
						free_q <= free_q + FW'(1);
					end
					if (cnt_q == 7'd0) begin
						refs_first_q <= upd.ent.refs;
					end
					cnt_q <= cnt_q + 7'd1;
					if (last_claim) begin
						done_q      <= 1'b1;
						status_q    <= bpa_pkg::STAT_OK;
						first_out_q <= first_ext[9:0];
						refs_out_q  <= (cnt_q == 7'd0) ? upd.ent.refs : refs_first_q;
						state_q     <= ST_IDLE;
					end else begin
						page_q  <= page_q + PW'(1);
						state_q <= ST_CL_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	logic [AW-1:0] free_ext;

	assign free_ext      = AW'(free_q);
	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign first_page    = first_out_q;
	assign ref_count_out = refs_out_q;
	assign free_pages    = free_ext[10:0];

	// free count never exceeds the number of pages
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		AW'(free_q) <= AW'(NUM_PAGES))
		else $error("free page count above page total");

	// a failed transfer reports no page and no count
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == bpa_pkg::STAT_NO_RUN || status_q == bpa_pkg::STAT_BAD_ZONE)
		|-> (first_out_q == '0 && refs_out_q == '0))
		else $error("failed result carries page data");

	// write-back always follows a read of the same entry
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CL_WR |-> $past(state_q) == ST_CL_RD && $stable(page_q))
		else $error("write-back without matching read");

	// nothing is reported while the memories are cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !done_q)
		else $error("result during clearing pass");

endmodule
